// ===== src/swat_pkg.sv =====
// shared types, codes and helpers for the sequence window ack tracker
package swat_pkg;

	localparam int unsigned SEQ_W = 16;
	localparam int unsigned ACK_OUT_W = 32;
	localparam logic [SEQ_W-1:0] SEQ_HALF = 16'h8000;

	typedef enum logic [1:0] {
		OP_INSERT     = 2'd0,
		OP_LOOKUP     = 2'd1,
		OP_ACK_NEWEST = 2'd2,
		OP_ACK_SEQ    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INS,
		ST_LOOK,
		ST_ACK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]       operation;
		logic [SEQ_W-1:0] seq;
	} req_word_t;

	typedef struct packed {
		logic                 hit;
		logic                 rejected;
		logic [ACK_OUT_W-1:0] ack_map;
	} rsp_word_t;

	typedef struct packed {
		logic             valid;
		logic [SEQ_W-1:0] tag;
	} slot_entry_t;

	// a is ahead of b in wrap-around order
	function automatic logic seq_ahead(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
		logic [SEQ_W-1:0] d;
		d = a - b;
		return (d != '0) && ((d < SEQ_HALF) || ((d == SEQ_HALF) && (a > b)));
	endfunction

endpackage

// ===== src/swat_req_if.sv =====
// request channel: operation and sequence number
interface swat_req_if;
	logic                valid;
	logic                ready;
	swat_pkg::req_word_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

// ===== src/swat_rsp_if.sv =====
// result channel: hit, rejected and ack mask
interface swat_rsp_if;
	logic                valid;
	logic                ready;
	swat_pkg::rsp_word_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

// ===== src/swat_slot_ram.sv =====
// slot store: one write port, one registered read port
module swat_slot_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW = 10
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  swat_pkg::slot_entry_t wdata,
	input  logic [AW-1:0]         raddr,
	output swat_pkg::slot_entry_t rdata
);
	import swat_pkg::*;

	slot_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== src/sequence_window_ack_tracker.sv =====
// top level of the sequence window ack tracker
// Tracks received sequence numbers in a slot store of WINDOW_DEPTH entries (a power of
// two), indexed by the low bits of the 16-bit number; each slot keeps a valid flag and
// the full number as tag, and a register keeps the newest accepted number. Insert is
// refused when the number is older than newest minus WINDOW_DEPTH, lookup hits on a
// valid slot whose tag matches, and the two ack operations build a mask whose bit i
// says that start minus i is present, start being the newest number or the given one.
// After reset the block sweeps the store once to clear the valid flags, one slot per
// cycle, so it takes no word until the sweep ends. Insert and lookup are accepted and
// then do one read or write of the store; an ack walks the store backwards through its
// single read port, one slot per cycle, one slot for each mask bit. When the previous
// result has not yet been taken, the new one is held until the output register frees.
// A new word is accepted while a finished result still waits in the output register.
module sequence_window_ack_tracker #(
	parameter int unsigned WINDOW_DEPTH = 1024,
	parameter int unsigned ACK_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	swat_req_if.sink   req,
	swat_rsp_if.source rsp
);
	import swat_pkg::*;

	localparam int unsigned AW = $clog2(WINDOW_DEPTH);
	localparam int unsigned CW = $clog2(ACK_WIDTH);
	localparam logic [AW-1:0] CLR_LAST = AW'(WINDOW_DEPTH - 1);
	localparam logic [CW-1:0] CNT_LAST = CW'(ACK_WIDTH - 1);
	localparam logic [SEQ_W-1:0] DEPTH_SEQ = SEQ_W'(WINDOW_DEPTH);

	// control state
	state_t           state_q, state_d;
	logic [SEQ_W-1:0] cur_q;       // number whose slot data is read back this cycle
	logic [SEQ_W-1:0] newest_q;
	logic [CW-1:0]    cnt_q;       // ack mask position being checked
	logic [AW-1:0]    clr_q;       // clearing sweep address
	logic [ACK_WIDTH-1:0] mask_q;
	rsp_word_t        res_q;       // finished result waiting for the output register
	logic             rsp_valid_q;
	rsp_word_t        rsp_word_q;

	// store access
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	slot_entry_t      mem_wdata;
	logic [AW-1:0]    mem_raddr;
	slot_entry_t      mem_rdata;

	logic             accept;
	logic             rsp_free;
	logic [SEQ_W-1:0] start_seq;
	logic             slot_match;
	logic             ins_reject;
	logic             done_now;
	logic [ACK_WIDTH-1:0] mask_next;
	rsp_word_t        res_now;

	swat_slot_ram #(
		.DEPTH(WINDOW_DEPTH),
		.AW   (AW)
	) u_slot_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign accept   = req.valid && req.ready;
	assign rsp_free = !rsp_valid_q || rsp.ready;

	// ack from newest starts at the stored newest number
	assign start_seq = (op_t'(req.word.operation) == OP_ACK_NEWEST) ? newest_q : req.word.seq;

	// read data belongs to cur_q
	assign slot_match = mem_rdata.valid && (mem_rdata.tag == cur_q);
	assign ins_reject = seq_ahead(newest_q - DEPTH_SEQ, cur_q);
	// shift in from the top so the first slot ends at bit 0
	assign mask_next  = {slot_match, mask_q[ACK_WIDTH-1:1]};

	assign done_now = (state_q == ST_INS) || (state_q == ST_LOOK) ||
		((state_q == ST_ACK) && (cnt_q == CNT_LAST));

	// result of the finishing state
	always_comb begin
		res_now = '0;
		case (state_q)
			ST_INS: begin
				res_now.hit      = !ins_reject;
				res_now.rejected = ins_reject;
			end
			ST_LOOK: begin
				res_now.hit = slot_match;
			end
			ST_ACK: begin
				res_now.ack_map = ACK_OUT_W'(mask_next);
			end
			default: begin
				res_now = res_q;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (op_t'(req.word.operation))
						OP_INSERT: state_d = ST_INS;
						OP_LOOKUP: state_d = ST_LOOK;
						OP_ACK_NEWEST, OP_ACK_SEQ: state_d = ST_ACK;
						default: state_d = ST_ACK;
					endcase
				end
			end
			ST_INS, ST_LOOK, ST_ACK: begin
				if (done_now) state_d = rsp_free ? ST_IDLE : ST_FINISH;
			end
			ST_FINISH: begin
				if (rsp_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs: handshake and store access
	always_comb begin
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cur_q[AW-1:0];
		mem_wdata = '{valid: 1'b1, tag: cur_q};
		mem_raddr = cur_q[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				mem_raddr = start_seq[AW-1:0];
			end
			ST_INS: begin
				mem_we = !ins_reject;
			end
			ST_ACK: begin
				mem_raddr = cur_q[AW-1:0] - AW'(1);
			end
			ST_LOOK, ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			newest_q    <= '0;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			// newest only moves forward on an accepted insert
			if ((state_q == ST_INS) && !ins_reject && seq_ahead(cur_q, newest_q)) begin
				newest_q <= cur_q;
			end
			if (accept) cnt_q <= '0;
			else if (state_q == ST_ACK) cnt_q <= cnt_q + CW'(1);
			if ((done_now || (state_q == ST_FINISH)) && rsp_free) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= start_seq;
		end else if (state_q == ST_ACK) begin
			cur_q <= cur_q - SEQ_W'(1);
		end
		if (state_q == ST_ACK) mask_q <= mask_next;
		if (done_now) res_q <= res_now;
		if ((done_now || (state_q == ST_FINISH)) && rsp_free) rsp_word_q <= res_now;
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.word  = rsp_word_q;

`ifndef SYNTHESIS
	// no word is taken during the clearing sweep
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !req.ready)
		else $error("word accepted during clearing sweep");

	// the store is written only by the sweep or an accepted insert
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == ST_CLEAR) || ((state_q == ST_INS) && !ins_reject)))
		else $error("unexpected store write");

	// newest moves only after an insert
	a_newest_ins: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(newest_q) |-> ($past(state_q) == ST_INS))
		else $error("newest changed outside insert");

	// a result never claims both hit and rejected
	a_hit_rej: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.word.hit && rsp.word.rejected))
		else $error("hit and rejected together");

	// an ack mask comes only with hit and rejected low
	a_ack_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.word.ack_map != '0)) |-> (!rsp.word.hit && !rsp.word.rejected))
		else $error("ack result carries flags");
`endif

endmodule
